// ----- rtl/core/asort_pkg.sv -----
// shared types, constants and helpers for the ascending sorter chain
package asort_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cell_cmd_e;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              valid;
    logic              gt;
  } cell_link_t;

  // sign flip makes an unsigned compare follow the signed order
  function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v);
    order_key = {~v[DATA_W-1], v[DATA_W-2:0]};
  endfunction

endpackage

// ----- rtl/core/asort_cell.sv -----
// one sorter cell: holds one value, inserts by compare, shifts toward the head
module asort_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  asort_pkg::cell_cmd_e        cmd_i,
  input  logic [asort_pkg::DATA_W-1:0] new_value_i,
  input  asort_pkg::cell_link_t       prev_i,
  input  asort_pkg::cell_link_t       next_i,
  output asort_pkg::cell_link_t       link_o
);
  import asort_pkg::*;

  logic [DATA_W-1:0] value_q, value_d;
  logic              valid_q, valid_d;
  logic              gt;
  logic              ins_self;
  logic              ins_prev;

  assign gt       = valid_q && (order_key(value_q) > order_key(new_value_i));
  assign ins_self = !valid_q || gt;
  assign ins_prev = !prev_i.valid || prev_i.gt;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (prev_i.valid && prev_i.gt) begin
          value_d = prev_i.value;
          valid_d = 1'b1;
        end else if (!ins_prev && ins_self) begin
          value_d = new_value_i;
          valid_d = 1'b1;
        end
      end
      CMD_SHIFT: begin
        value_d = next_i.value;
        valid_d = next_i.valid;
      end
      default: begin
        value_d = value_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.value = value_q;
  assign link_o.valid = valid_q;
  assign link_o.gt    = gt;

endmodule

// ----- rtl/core/ascending_array_sorter_core.sv -----
// ascending sorter: insertion chain of cells with a registered output stage
// load: one word per cycle, each word placed in its slot in the cycle it is taken
//   unless full, which sets the overflow flag; input is held off while draining
// drain: after tlast the chain shifts one slot per cycle while output is free,
//   toward the single drain port at cell 0, giving one sorted word per cycle
// reset: asynchronous active low, empties the chain and clears the overflow flag
module ascending_array_sorter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [asort_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                         s_axis_tlast_i,  // is_last
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [asort_pkg::DATA_W-1:0] m_axis_tdata_o,  // [31:0] sorted_value
  output logic                         m_axis_tlast_o,  // last_out
  output logic                         m_axis_tuser_o   // [0] overflowed
);
  import asort_pkg::*;

  cell_link_t        links [MAX_ITEMS];
  cell_cmd_e         cmd;
  logic [CNT_W-1:0]  count_q;
  logic              overflow_q;
  logic              draining_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_last_q;
  logic              out_ovf_q;
  logic              accept;
  logic              full;
  logic              out_free;
  logic              drain_step;

  localparam cell_link_t HeadLink = '{value: '0, valid: 1'b1, gt: 1'b0};
  localparam cell_link_t TailLink = '{value: '0, valid: 1'b0, gt: 1'b0};

  assign s_axis_tready_o = !draining_q;
  assign accept          = s_axis_tvalid_i && !draining_q;
  assign full            = (count_q == CNT_W'(MAX_ITEMS));
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign drain_step      = draining_q && out_free;

  always_comb begin
    if (accept && !full) begin
      cmd = CMD_INSERT;
    end else if (drain_step) begin
      cmd = CMD_SHIFT;
    end else begin
      cmd = CMD_HOLD;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_link_t prev_link;
    cell_link_t next_link;
    if (i == 0) begin : g_head
      assign prev_link = HeadLink;
    end else begin : g_prev
      assign prev_link = links[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_link = TailLink;
    end else begin : g_next
      assign next_link = links[i+1];
    end
    asort_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .new_value_i (s_axis_tdata_i),
      .prev_i      (prev_link),
      .next_i      (next_link),
      .link_o      (links[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      overflow_q  <= 1'b0;
      draining_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (full) begin
          overflow_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
        if (s_axis_tlast_i) begin
          draining_q <= 1'b1;
        end
      end
      if (drain_step) begin
        out_valid_q <= 1'b1;
        count_q     <= count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          draining_q <= 1'b0;
          overflow_q <= 1'b0;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_step) begin
      out_data_q <= links[0].value;
      out_last_q <= (count_q == CNT_W'(1));
      out_ovf_q  <= overflow_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

endmodule
